>>> rtl/rfp_pkg.sv
// Shared types and constants for the ring FIFO with peek unit.
// Holds the command codes and the result flag bundle; no dependencies.
`default_nettype none

package rfp_pkg;

    // Widths of the command and data ports, fixed by the interface.
    localparam int CMD_BITS     = 3;
    localparam int IO_WORD_BITS = 8;

    typedef enum logic [CMD_BITS-1:0] {
        CMD_STATUS     = 3'd0,
        CMD_INSERT     = 3'd1,
        CMD_REMOVE     = 3'd2,
        CMD_START_PEEK = 3'd3,
        CMD_PEEK       = 3'd4,
        CMD_CLEAR      = 3'd5
    } cmd_t;

    // Flags that travel with a command from issue to the output register.
    typedef struct packed {
        logic use_data;   // read_word comes from the memory read data
        logic is_empty;
        logic is_full;
        logic op_error;
    } res_flags_t;

endpackage

`default_nettype wire

>>> rtl/rfp_ram.sv
// Generic single-port-write, single-port-read synchronous RAM.
// Read data is registered and holds while no read is issued; no dependencies.
`default_nettype none

module rfp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output      logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

>>> rtl/ring_fifo_with_peek_unit.sv
// Top level of the ring FIFO with peek unit: command decode, pointers,
// fill count and output register. Depends on rfp_pkg and rfp_ram.
//
// Usage: each transfer on the input channel (in_valid/in_ready) carries one
// command and a write word. Each command produces exactly one transfer on
// the output channel (out_valid/out_ready) carrying the read word, the
// occupancy after the command, the empty and full flags and an error flag
// for an insert on a full FIFO or a remove on an empty one.
//
// Throughput is one command per cycle while the receiver keeps up. The memory
// is accessed in the cycle a command is accepted and its registered read data
// is captured into the output register when the issue stage hands its result
// on, so each result passes the issue stage and then the output register.
// Commands touch the memory at most once each and one command is issued per
// cycle, so no read ever meets a write of the same cycle.
//
// Reset clears the pointers, the count and all handshake state at once.
// The memory itself is not swept: a high-water mark records how many
// entries have been written since reset (writes always start at entry zero
// and move up in order), and a read of an entry at or above the mark returns zero.
// When the receiver stalls, the result waits in the output register and one
// more command can be accepted into the issue stage; after that in_ready
// drops until the output transfer completes.
`default_nettype none

module ring_fifo_with_peek_unit
    import rfp_pkg::*;
#(
    parameter int DEPTH     = 64,
    parameter int WORD_BITS = 8
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           in_valid,
    output      logic                           in_ready,
    input  wire logic [CMD_BITS-1:0]            command,
    input  wire logic [IO_WORD_BITS-1:0]        write_word,
    output      logic                           out_valid,
    input  wire logic                           out_ready,
    output      logic [IO_WORD_BITS-1:0]        read_word,
    output      logic [$clog2(DEPTH+1)-1:0]     occupancy,
    output      logic                           is_empty,
    output      logic                           is_full,
    output      logic                           op_error
);

    localparam int PTR_BITS = $clog2(DEPTH);
    localparam int CNT_BITS = $clog2(DEPTH + 1);
    localparam logic [CNT_BITS-1:0] CNT_FULL = CNT_BITS'(DEPTH);
    localparam logic [PTR_BITS-1:0] PTR_LAST = PTR_BITS'(DEPTH - 1);

    // Step a pointer by one and wrap it at the last entry.
    function automatic logic [PTR_BITS-1:0] advance(input logic [PTR_BITS-1:0] p);
        return (p == PTR_LAST) ? '0 : p + 1'b1;
    endfunction

    // Pointer and occupancy state.
    logic [PTR_BITS-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_BITS-1:0] rd_ptr_reg, rd_ptr_next;
    logic [PTR_BITS-1:0] pk_ptr_reg, pk_ptr_next;
    logic [CNT_BITS-1:0] count_reg, count_next;
    // Number of entries written at least once since reset.
    logic [CNT_BITS-1:0] hw_reg, hw_next;

    // Issue stage: the command whose memory read is in flight.
    logic                pend_valid_reg, pend_valid_next;
    res_flags_t          pend_flags_reg, pend_flags_next;
    logic [CNT_BITS-1:0] pend_count_reg;

    // Output register.
    logic                    out_valid_reg, out_valid_next;
    logic [IO_WORD_BITS-1:0] out_word_reg;
    logic [CNT_BITS-1:0]     out_count_reg;
    res_flags_t              out_flags_reg;

    // Memory interface.
    logic                 ram_we;
    logic                 ram_re;
    logic [PTR_BITS-1:0]  ram_raddr;
    logic [WORD_BITS-1:0] ram_wdata;
    logic [WORD_BITS-1:0] ram_rdata;

    logic accept;
    logic pend_move;
    cmd_t cmd;

    logic [WORD_BITS+IO_WORD_BITS-1:0] wr_ext;
    logic [WORD_BITS+IO_WORD_BITS-1:0] rd_ext;

    // The issue stage hands its result on whenever the output register is
    // free or being emptied, and a new command may enter in that same cycle.
    assign pend_move = pend_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready  = !pend_valid_reg || pend_move;
    assign accept    = in_valid && in_ready;
    assign cmd       = cmd_t'(command);

    // Fit the port word to the stored word width and back again.
    assign wr_ext    = {{WORD_BITS{1'b0}}, write_word};
    assign ram_wdata = wr_ext[WORD_BITS-1:0];
    assign rd_ext    = {{IO_WORD_BITS{1'b0}}, ram_rdata};

    always_comb
    begin
        wr_ptr_next     = wr_ptr_reg;
        rd_ptr_next     = rd_ptr_reg;
        pk_ptr_next     = pk_ptr_reg;
        count_next      = count_reg;
        hw_next         = hw_reg;
        ram_we          = 1'b0;
        ram_re          = 1'b0;
        ram_raddr       = rd_ptr_reg;
        pend_flags_next = '0;

        if (accept)
        begin
            unique case (cmd)
                CMD_INSERT:
                begin
                    if (count_reg == CNT_FULL)
                    begin
                        pend_flags_next.op_error = 1'b1;
                    end
                    else
                    begin
                        ram_we      = 1'b1;
                        wr_ptr_next = advance(wr_ptr_reg);
                        count_next  = count_reg + 1'b1;
                        // Writes climb in order from entry zero, so the
                        // mark only moves when the write lands right on it.
                        if (CNT_BITS'(wr_ptr_reg) == hw_reg)
                        begin
                            hw_next = hw_reg + 1'b1;
                        end
                    end
                end
                CMD_REMOVE:
                begin
                    if (count_reg == '0)
                    begin
                        pend_flags_next.op_error = 1'b1;
                    end
                    else
                    begin
                        ram_re                   = 1'b1;
                        ram_raddr                = rd_ptr_reg;
                        pend_flags_next.use_data = CNT_BITS'(rd_ptr_reg) < hw_reg;
                        rd_ptr_next              = advance(rd_ptr_reg);
                        count_next               = count_reg - 1'b1;
                    end
                end
                CMD_START_PEEK:
                begin
                    pk_ptr_next = rd_ptr_reg;
                end
                CMD_PEEK:
                begin
                    ram_re                   = 1'b1;
                    ram_raddr                = pk_ptr_reg;
                    pend_flags_next.use_data = CNT_BITS'(pk_ptr_reg) < hw_reg;
                    pk_ptr_next              = advance(pk_ptr_reg);
                end
                CMD_CLEAR:
                begin
                    wr_ptr_next = '0;
                    rd_ptr_next = '0;
                    pk_ptr_next = '0;
                    count_next  = '0;
                end
                default:
                begin
                    // Status and the unused codes change nothing.
                end
            endcase
        end

        pend_flags_next.is_empty = (count_next == '0);
        pend_flags_next.is_full  = (count_next == CNT_FULL);
    end

    always_comb
    begin
        priority if (accept)
        begin
            pend_valid_next = 1'b1;
        end
        else if (pend_move)
        begin
            pend_valid_next = 1'b0;
        end
        else
        begin
            pend_valid_next = pend_valid_reg;
        end

        priority if (pend_move)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg     <= '0;
            rd_ptr_reg     <= '0;
            pk_ptr_reg     <= '0;
            count_reg      <= '0;
            hw_reg         <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            wr_ptr_reg     <= wr_ptr_next;
            rd_ptr_reg     <= rd_ptr_next;
            pk_ptr_reg     <= pk_ptr_next;
            count_reg      <= count_next;
            hw_reg         <= hw_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // Payload registers need no reset.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            pend_flags_reg <= pend_flags_next;
            pend_count_reg <= count_next;
        end
        if (pend_move)
        begin
            out_word_reg  <= pend_flags_reg.use_data ? rd_ext[IO_WORD_BITS-1:0] : '0;
            out_count_reg <= pend_count_reg;
            out_flags_reg <= pend_flags_reg;
        end
    end

    rfp_ram #(
        .WIDTH (WORD_BITS),
        .DEPTH (DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (wr_ptr_reg),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign out_valid = out_valid_reg;
    assign read_word = out_word_reg;
    assign occupancy = out_count_reg;
    assign is_empty  = out_flags_reg.is_empty;
    assign is_full   = out_flags_reg.is_full;
    assign op_error  = out_flags_reg.op_error;

endmodule

`default_nettype wire

>>> rtl/rfp_checker.sv
// Port-level checker for the ring FIFO with peek unit, and its bind.
// Depends on rfp_pkg; attaches to ring_fifo_with_peek_unit.
`default_nettype none

module rfp_checker
    import rfp_pkg::*;
#(
    parameter int DEPTH = 64
) (
    input wire logic                       clk,
    input wire logic                       rst_n,
    input wire logic                       in_valid,
    input wire logic                       in_ready,
    input wire logic                       out_valid,
    input wire logic                       out_ready,
    input wire logic [IO_WORD_BITS-1:0]    read_word,
    input wire logic [$clog2(DEPTH+1)-1:0] occupancy,
    input wire logic                       is_empty,
    input wire logic                       is_full,
    input wire logic                       op_error
);

    localparam int CNT_BITS = $clog2(DEPTH + 1);

    // A stalled result stays offered.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result dropped while stalled");

    // The flags agree with the reported occupancy.
    a_flags: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (is_empty == (occupancy == '0)) &&
                      (is_full == (occupancy == CNT_BITS'(DEPTH))))
        else $error("empty or full flag disagrees with occupancy");

    // Occupancy never exceeds the depth.
    a_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> occupancy <= CNT_BITS'(DEPTH))
        else $error("occupancy beyond depth");

    // A refused command returns no data.
    a_err_word: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && op_error |-> read_word == '0)
        else $error("refused command returned data");

    // With no result held, the unit can always take a command.
    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid && !$past(in_valid && in_ready) |-> in_ready)
        else $error("input stalled with nothing in flight");

endmodule

bind ring_fifo_with_peek_unit rfp_checker #(
    .DEPTH (DEPTH)
) u_rfp_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .read_word (read_word),
    .occupancy (occupancy),
    .is_empty  (is_empty),
    .is_full   (is_full),
    .op_error  (op_error)
);

`default_nettype wire

>>> test/ring_fifo_checker.sv
// Checker for the ring FIFO with peek unit: watches both channels, predicts each result
// from its own copy of the FIFO state and compares the results field by field.
// Depends on rfp_pkg for the command codes.
module ring_fifo_checker
    import rfp_pkg::*;
#(
    parameter int DEPTH = 64
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    input  logic                          in_ready,
    input  logic [CMD_BITS-1:0]           command,
    input  logic [IO_WORD_BITS-1:0]       write_word,
    input  logic                          out_valid,
    input  logic                          out_ready,
    input  logic [IO_WORD_BITS-1:0]       read_word,
    input  logic [$clog2(DEPTH+1)-1:0]    occupancy,
    input  logic                          is_empty,
    input  logic                          is_full,
    input  logic                          op_error,
    output int                            mismatch_count,
    output int                            results_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int PTR_BITS = $clog2(DEPTH);
    localparam int OCC_BITS = $clog2(DEPTH+1);

    typedef struct packed {
        logic [IO_WORD_BITS-1:0] word;
        logic [OCC_BITS-1:0]     occ;
        logic                    empty;
        logic                    full;
        logic                    err;
    } fifo_result_t;

    // Shadow copy of the FIFO; the store is all zeros after reset.
    logic [IO_WORD_BITS-1:0] shadow_mem [DEPTH];
    logic [PTR_BITS-1:0]     wr_slot = '0;
    logic [PTR_BITS-1:0]     rd_slot = '0;
    logic [PTR_BITS-1:0]     peek_slot = '0;
    logic [OCC_BITS-1:0]     fill = '0;

    fifo_result_t            owed_results [$];

    initial
    begin
        mismatch_count  = 0;
        results_pending = 0;
        for (int i = 0; i < DEPTH; i++)
        begin
            shadow_mem[i] = '0;
        end
    end

    function automatic logic [PTR_BITS-1:0] next_slot(input logic [PTR_BITS-1:0] p);
        return (p == PTR_BITS'(DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    // Applies one command to the shadow FIFO and returns the result it must produce.
    function automatic fifo_result_t apply_command(input logic [CMD_BITS-1:0] code,
                                                   input logic [IO_WORD_BITS-1:0] word);
        fifo_result_t r;
        r = '0;
        case (cmd_t'(code))
            CMD_INSERT:
            begin
                if (fill == OCC_BITS'(DEPTH))
                begin
                    r.err = 1'b1;
                end
                else
                begin
                    shadow_mem[wr_slot] = word;
                    wr_slot = next_slot(wr_slot);
                    fill = fill + 1'b1;
                end
            end
            CMD_REMOVE:
            begin
                if (fill == '0)
                begin
                    r.err = 1'b1;
                end
                else
                begin
                    r.word = shadow_mem[rd_slot];
                    rd_slot = next_slot(rd_slot);
                    fill = fill - 1'b1;
                end
            end
            CMD_START_PEEK:
            begin
                peek_slot = rd_slot;
            end
            CMD_PEEK:
            begin
                r.word = shadow_mem[peek_slot];
                peek_slot = next_slot(peek_slot);
            end
            CMD_CLEAR:
            begin
                wr_slot   = '0;
                rd_slot   = '0;
                peek_slot = '0;
                fill      = '0;
            end
            default:
            begin
            end
        endcase
        r.occ   = fill;
        r.empty = (fill == '0);
        r.full  = (fill == OCC_BITS'(DEPTH));
        return r;
    endfunction

    always @(posedge clk)
    begin
        fifo_result_t want;
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                if (owed_results.size() == 0)
                begin
                    $display("%0t: result transfer with none outstanding: word %0h occupancy %0d",
                             $time, read_word, occupancy);
                    mismatch_count++;
                end
                else
                begin
                    want = owed_results.pop_front();
                    if (read_word !== want.word)
                    begin
                        $display("%0t: read_word expected %0h actual %0h",
                                 $time, want.word, read_word);
                        mismatch_count++;
                    end
                    if (occupancy !== want.occ)
                    begin
                        $display("%0t: occupancy expected %0d actual %0d",
                                 $time, want.occ, occupancy);
                        mismatch_count++;
                    end
                    if (is_empty !== want.empty)
                    begin
                        $display("%0t: is_empty expected %0b actual %0b",
                                 $time, want.empty, is_empty);
                        mismatch_count++;
                    end
                    if (is_full !== want.full)
                    begin
                        $display("%0t: is_full expected %0b actual %0b",
                                 $time, want.full, is_full);
                        mismatch_count++;
                    end
                    if (op_error !== want.err)
                    begin
                        $display("%0t: op_error expected %0b actual %0b",
                                 $time, want.err, op_error);
                        mismatch_count++;
                    end
                end
            end
            if (in_valid && in_ready)
            begin
                owed_results.push_back(apply_command(command, write_word));
            end
            results_pending <= owed_results.size();
        end
    end

endmodule

>>> test/testbench.sv
// Top of the ring FIFO with peek regression: clock, reset, command stimulus and verdict.
// Depends on rfp_pkg, ring_fifo_with_peek_unit and ring_fifo_checker.
module testbench;
    import rfp_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int DEPTH        = 64;
    localparam int OCC_BITS     = $clog2(DEPTH+1);
    localparam int RANDOM_ITEMS = 1350;

    // Every input of the block holds a known value from time zero on.
    logic                       clk = 1'b0;
    logic                       rst_n = 1'b0;
    logic                       in_valid = 1'b0;
    cmd_t                       command = CMD_STATUS;
    logic [IO_WORD_BITS-1:0]    write_word = '0;
    logic                       out_ready = 1'b0;

    logic                       in_ready;
    logic                       out_valid;
    logic [IO_WORD_BITS-1:0]    read_word;
    logic [OCC_BITS-1:0]        occupancy;
    logic                       is_empty;
    logic                       is_full;
    logic                       op_error;

    int                         mismatch_count;
    int                         results_pending;

    // Sender bookkeeping: commands left in the current burst and commands sent so far.
    int                         burst_left = 0;
    int                         sent_items = 0;

    ring_fifo_with_peek_unit #(
        .DEPTH     (DEPTH),
        .WORD_BITS (IO_WORD_BITS)
    ) DUT (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .command    (command),
        .write_word (write_word),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .read_word  (read_word),
        .occupancy  (occupancy),
        .is_empty   (is_empty),
        .is_full    (is_full),
        .op_error   (op_error)
    );

    // The checker sits beside the block, sees the same pins and reports back a failure
    // count and the number of results still owed by the block.
    ring_fifo_checker #(
        .DEPTH (DEPTH)
    ) checker_inst (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .command         (command),
        .write_word      (write_word),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .read_word       (read_word),
        .occupancy       (occupancy),
        .is_empty        (is_empty),
        .is_full         (is_full),
        .op_error        (op_error),
        .mismatch_count  (mismatch_count),
        .results_pending (results_pending)
    );

    initial
    begin
        forever #6 clk = ~clk;
    end

    // The run is bounded by a fixed time far beyond the slowest legal run: about
    // 1400 commands, each of which may be held up by receiver stalls.
    initial
    begin
        #5_000_000;
        $display("Regression FAIL");
        $finish;
    end

    // The receiver runs through modes of random length: always ready, coin-flip
    // ready, ready one cycle in four, and mostly stalled. The always-ready mode
    // gives stretches where results drain at full rate.
    initial
    begin
        int rx_mode;
        int rx_left;
        int rx_phase;
        rx_mode  = 0;
        rx_left  = 0;
        rx_phase = 0;
        forever
        begin
            @(posedge clk);
            if (rx_left == 0)
            begin
                rx_mode = $urandom_range(0, 3);
                rx_left = $urandom_range(20, 200);
            end
            rx_left--;
            rx_phase++;
            case (rx_mode)
                0: out_ready <= 1'b1;
                1: out_ready <= 1'($urandom_range(0, 1));
                2: out_ready <= ((rx_phase % 4) == 0);
                default: out_ready <= ($urandom_range(0, 9) == 0);
            endcase
        end
    end

    // Offers one command and waits for its transfer. The sender works in bursts:
    // when a burst is used up it may drop valid before the next one starts. Valid
    // stays high between commands of one burst, so each edge sees at most one
    // assignment to it.
    task automatic push_command(input cmd_t code, input logic [IO_WORD_BITS-1:0] word);
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = ($urandom_range(0, 7) == 0) ? 200 : $urandom_range(1, 24);
        end
        in_valid   <= 1'b1;
        command    <= code;
        write_word <= word;
        // in_ready is read before the edge's updates settle, so it is the value that
        // decided the transfer at this edge.
        do @(posedge clk); while (!in_ready);
        burst_left--;
        sent_items++;
    endtask

    // Stops sending and holds off until the block owes no more results. The first
    // edge lets the checker count the command that was just transferred.
    task automatic wait_until_drained();
        in_valid <= 1'b0;
        burst_left = 0;
        do @(posedge clk); while (results_pending != 0);
    endtask

    // Data words lean toward the extremes so that all-zero and all-one words show up.
    function automatic logic [IO_WORD_BITS-1:0] pick_word();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return '1;
            default: return IO_WORD_BITS'($urandom_range(0, 255));
        endcase
    endfunction

    // A mix weighted toward traffic that moves data: inserts, removes and peeks.
    function automatic cmd_t pick_mixed_command();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 35) return CMD_INSERT;
        else if (roll < 65) return CMD_REMOVE;
        else if (roll < 73) return CMD_STATUS;
        else if (roll < 80) return CMD_START_PEEK;
        else if (roll < 95) return CMD_PEEK;
        else return CMD_CLEAR;
    endfunction

    initial
    begin
        int seq_kind;
        int run_len;
        int next_pause;

        // Reset is held low from time zero and released on a rising edge.
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed opening: status and underflow on an empty FIFO, peek of a cleared
        // store, words at the extremes, a peek walk past the stored words, clear that
        // keeps the store, and underflow again after the clear.
        push_command(CMD_STATUS, 8'h00);
        push_command(CMD_REMOVE, 8'hFF);
        push_command(CMD_PEEK, 8'h00);
        push_command(CMD_START_PEEK, 8'h00);
        push_command(CMD_INSERT, 8'h00);
        push_command(CMD_INSERT, 8'hFF);
        push_command(CMD_INSERT, 8'hA5);
        push_command(CMD_INSERT, 8'h5A);
        push_command(CMD_START_PEEK, 8'h00);
        push_command(CMD_PEEK, 8'h00);
        push_command(CMD_PEEK, 8'h00);
        push_command(CMD_PEEK, 8'h00);
        push_command(CMD_PEEK, 8'h00);
        push_command(CMD_PEEK, 8'h00);
        push_command(CMD_REMOVE, 8'h00);
        push_command(CMD_REMOVE, 8'h00);
        push_command(CMD_STATUS, 8'hFF);
        push_command(CMD_CLEAR, 8'h00);
        push_command(CMD_REMOVE, 8'h00);
        push_command(CMD_PEEK, 8'h00);
        push_command(CMD_INSERT, 8'h3C);
        push_command(CMD_REMOVE, 8'h00);

        // Hold off here until every outstanding result has come back.
        wait_until_drained();

        // The random part opens by filling past full and draining past empty so
        // that both refusal cases and the pointer wrap are certain to be seen.
        sent_items = 0;
        repeat (DEPTH + 3) push_command(CMD_INSERT, pick_word());
        push_command(CMD_START_PEEK, pick_word());
        repeat (DEPTH + 2) push_command(CMD_PEEK, pick_word());
        repeat (DEPTH + 3) push_command(CMD_REMOVE, pick_word());

        // The rest is a chain of short sequences with random content: fill runs,
        // drain runs, peek walks from the read pointer, random mixes and clears.
        // Fill and drain runs long enough to hit full and empty are common.
        next_pause = 300;
        while (sent_items < RANDOM_ITEMS)
        begin
            seq_kind = $urandom_range(0, 99);
            run_len  = $urandom_range(1, 70);
            if (seq_kind < 25)
            begin
                repeat (run_len) push_command(CMD_INSERT, pick_word());
            end
            else if (seq_kind < 50)
            begin
                repeat (run_len) push_command(CMD_REMOVE, pick_word());
            end
            else if (seq_kind < 65)
            begin
                push_command(CMD_START_PEEK, pick_word());
                repeat (run_len) push_command(CMD_PEEK, pick_word());
            end
            else if (seq_kind < 97)
            begin
                repeat ($urandom_range(1, 30)) push_command(pick_mixed_command(), pick_word());
            end
            else
            begin
                push_command(CMD_CLEAR, pick_word());
            end
            if (sent_items >= next_pause)
            begin
                wait_until_drained();
                next_pause += 300;
            end
        end

        // Drain everything, then wait on for any stray result to appear.
        wait_until_drained();
        repeat (4) @(posedge clk);

        if (mismatch_count == 0 && results_pending == 0)
        begin
            $display("Regression PASS");
        end
        else
        begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
